// ----- design/saclru_pkg.sv -----
// ----------------------------------------------------------------------------
// saclru_pkg
// Shared types and constants for the set-associative cache lookup with
// counter-based LRU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package saclru_pkg;

    localparam int NUM_SETS_DEF    = 64;
    localparam int NUM_WAYS_DEF    = 4;
    localparam int OFFSET_BITS_DEF = 4;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int ADDR_W     = 32;
    localparam int ADDR_EXT_W = 48;
    localparam int AGE_W      = 16;
    localparam int WAY_OUT_W  = 2;
    localparam int VTAG_W     = 22;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_t;

endpackage

`default_nettype wire

// ----- design/saclru_if.sv -----
// ----------------------------------------------------------------------------
// saclru_req_if / saclru_rsp_if
// Valid/ready channels for access requests and lookup responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface saclru_req_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [saclru_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface saclru_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [saclru_pkg::WAY_OUT_W-1:0]  way;
    logic                              writeback;
    logic [saclru_pkg::VTAG_W-1:0]     victim_tag;

    modport source (output valid, output hit, output way, output writeback,
                    output victim_tag, input ready);
    modport sink   (input valid, input hit, input way, input writeback,
                    input victim_tag, output ready);
endinterface

`default_nettype wire

// ----- design/saclru_ctrl.sv -----
// ----------------------------------------------------------------------------
// saclru_ctrl
// Controller: sequences accept, set-row read and row commit, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module saclru_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output saclru_pkg::ctrl_t       ctrl
);

    saclru_pkg::state_t state_reg;
    saclru_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_comb
    begin
        ctrl.accept    = (state_reg == saclru_pkg::ST_IDLE) && in_valid;
        ctrl.commit    = (state_reg == saclru_pkg::ST_LOOKUP) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            saclru_pkg::ST_IDLE:
            begin
                if (ctrl.accept)
                begin
                    state_next = saclru_pkg::ST_LOOKUP;
                end
            end
            saclru_pkg::ST_LOOKUP:
            begin
                if (ctrl.commit)
                begin
                    state_next = saclru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = saclru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= saclru_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == saclru_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/saclru_dpath.sv -----
// ----------------------------------------------------------------------------
// saclru_dpath
// Datapath: address split, set-row memory, tag match, LRU victim choice,
// age update and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module saclru_dpath #(
    parameter int NUM_SETS    = saclru_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = saclru_pkg::NUM_WAYS_DEF,
    parameter int OFFSET_BITS = saclru_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = saclru_pkg::ADDR_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire saclru_pkg::ctrl_t                  ctrl,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_wr_data,
    input  wire logic                               cmd,
    input  wire logic [saclru_pkg::ADDR_W-1:0]      address,
    output logic                                    hit,
    output logic [saclru_pkg::WAY_OUT_W-1:0]        way,
    output logic                                    writeback,
    output logic [saclru_pkg::VTAG_W-1:0]           victim_tag
);

    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int LINE_W   = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_W    = LINE_W - SET_BITS;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W    = saclru_pkg::AGE_W;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [AGE_W-1:0]   age;
        logic [TAG_W-1:0]   tag;
    } way_entry_t;

    typedef way_entry_t [NUM_WAYS-1:0] row_t;

    row_t                           mem [NUM_SETS];
    row_t                           rd_row_reg;
    logic [NUM_SETS-1:0]            set_init_reg;
    logic                           init_reg;
    logic [SET_W-1:0]               set_reg;
    logic [TAG_W-1:0]               tag_reg;
    logic                           write_reg;
    logic                           wbm_reg;
    logic                           hit_reg;
    logic [saclru_pkg::WAY_OUT_W-1:0] way_reg;
    logic                           wb_reg;
    logic [saclru_pkg::VTAG_W-1:0]  vtag_reg;

    logic [saclru_pkg::ADDR_EXT_W-1:0] addr_ext;
    logic [LINE_W-1:0]              line_num;
    logic [SET_W-1:0]               set_idx;
    logic [TAG_W-1:0]               tag_in;

    row_t                           row_cur;
    row_t                           row_next;
    logic                           hit_c;
    logic [WAY_W-1:0]               sel_c;
    logic                           wb_c;
    logic [saclru_pkg::VTAG_W-1:0]  vtag_c;

    assign addr_ext = saclru_pkg::ADDR_EXT_W'(address);
    assign line_num = addr_ext[ADDR_BITS-1:OFFSET_BITS];
    assign set_idx  = (NUM_SETS > 1) ? SET_W'(line_num) : '0;
    assign tag_in   = TAG_W'(line_num >> SET_BITS);

    always_comb
    begin
        logic [AGE_W-1:0] best;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] old_way;
        logic             found;

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_cur[w]       = rd_row_reg[w];
            row_cur[w].valid = init_reg & rd_row_reg[w].valid;
            row_cur[w].dirty = init_reg & rd_row_reg[w].dirty;
            row_cur[w].age   = init_reg ? rd_row_reg[w].age : '0;
        end

        found   = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row_cur[w].valid && (row_cur[w].tag == tag_reg))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        best    = row_cur[0].age;
        old_way = '0;
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            if (row_cur[w].age > best)
            begin
                best    = row_cur[w].age;
                old_way = WAY_W'(w);
            end
        end

        hit_c = found;
        sel_c = found ? hit_way : old_way;

        wb_c   = !found && wbm_reg && row_cur[sel_c].valid && row_cur[sel_c].dirty;
        vtag_c = wb_c ? saclru_pkg::VTAG_W'(row_cur[sel_c].tag) : '0;

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_next[w] = row_cur[w];
            if (row_cur[w].age != saclru_pkg::AGE_MAX)
            begin
                row_next[w].age = row_cur[w].age + AGE_W'(1);
            end
            if (WAY_W'(w) == sel_c)
            begin
                row_next[w].age = '0;
                if (!found)
                begin
                    row_next[w].valid = 1'b1;
                    row_next[w].dirty = 1'b0;
                    row_next[w].tag   = tag_reg;
                end
                if ((write_reg == saclru_pkg::CMD_WRITE) && wbm_reg)
                begin
                    row_next[w].dirty = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            mem[set_reg] <= row_next;
        end
        if (ctrl.accept)
        begin
            rd_row_reg <= mem[set_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            set_reg   <= set_idx;
            tag_reg   <= tag_in;
            write_reg <= cmd;
        end
        if (ctrl.commit)
        begin
            hit_reg  <= hit_c;
            way_reg  <= saclru_pkg::WAY_OUT_W'(sel_c);
            wb_reg   <= wb_c;
            vtag_reg <= vtag_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_init_reg <= '0;
            init_reg     <= 1'b0;
            wbm_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wbm_reg <= cfg_wr_data;
            end
            if (ctrl.accept)
            begin
                init_reg <= set_init_reg[set_idx];
            end
            if (ctrl.commit)
            begin
                set_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    assign hit        = hit_reg;
    assign way        = way_reg;
    assign writeback  = wb_reg;
    assign victim_tag = vtag_reg;

endmodule

`default_nettype wire

// ----- design/set_assoc_cache_lru_lookup_unit.sv -----
// Accept loads the set row and tag into registers; the response is
// registered at row commit, which waits while a prior response is stalled.
// A new request is taken only after the current one finishes its set-row
// memory read and the row write-back of tags, ages and line state.
// Reset: asynchronous; per-set initialised flags clear at once, so no
// clearing pass is needed; write_back_mode returns to 1.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_unit
// Set-associative cache tag lookup with counter-based LRU replacement and
// dirty-victim reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_lookup_unit #(
    parameter int NUM_SETS    = saclru_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = saclru_pkg::NUM_WAYS_DEF,
    parameter int OFFSET_BITS = saclru_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = saclru_pkg::ADDR_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    saclru_req_if.sink      req,
    saclru_rsp_if.source    rsp
);

    saclru_pkg::ctrl_t ctrl;
    logic              in_ready;
    logic              out_valid;

    saclru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    saclru_dpath #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (req.cmd),
        .address     (req.address),
        .hit         (rsp.hit),
        .way         (rsp.way),
        .writeback   (rsp.writeback),
        .victim_tag  (rsp.victim_tag)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ----- design/saclru_checker.sv -----
// ----------------------------------------------------------------------------
// saclru_checker
// Port-level checks for the cache lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module saclru_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic                                rsp_hit,
    input wire logic [saclru_pkg::WAY_OUT_W-1:0]    rsp_way,
    input wire logic                                rsp_writeback,
    input wire logic [saclru_pkg::VTAG_W-1:0]       rsp_victim_tag
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way)
            && $stable(rsp_writeback) && $stable(rsp_victim_tag))
        else $error("response changed while stalled");

    a_wb_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_writeback |-> !rsp_hit)
        else $error("writeback reported on a hit");

    a_vtag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_writeback |-> rsp_victim_tag == '0)
        else $error("victim tag set without writeback");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction accepted while one is in flight");

    a_rsp_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a preceding request");

endmodule

bind set_assoc_cache_lru_lookup_unit saclru_checker u_saclru_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_way        (rsp.way),
    .rsp_writeback  (rsp.writeback),
    .rsp_victim_tag (rsp.victim_tag)
);

`default_nettype wire
